// ----- rtl/dpss_pkg.sv -----
// ----------------------------------------------------------------------------
// Dirty parameter sync scheduler package
// Shared constants, codes and the input item type of the scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package dpss_pkg;

  localparam int MAX_ENTRIES  = 16;
  localparam int IDX_W        = $clog2(MAX_ENTRIES);
  localparam int ENT_W        = $clog2(MAX_ENTRIES + 1);
  localparam int COUNTER_BITS = 16;
  localparam int CFG_W        = 5;

  localparam logic [ENT_W-1:0] NONE_ENTRY         = ENT_W'(MAX_ENTRIES);
  localparam logic [7:0]       ACK_TYPE_SET_PARAM = 8'h01;

  typedef enum logic [1:0] {
    MODE_TICK     = 2'd0,
    MODE_MARK     = 2'd1,
    MODE_MARK_ALL = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_OK   = 2'd1,
    RES_FAIL = 2'd2
  } result_e;

  typedef enum logic [1:0] {
    CMD_DONE        = 2'd0,
    CMD_OFFLINE     = 2'd1,
    CMD_VEH_ACTIVE  = 2'd2
  } cmd_status_e;

  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_ERR = 1'b1;

  typedef struct packed {
    logic [1:0]       mode;
    logic [IDX_W-1:0] param_index;
    logic             link_online;
    logic             control_enabled;
    logic             emergency_stop;
    logic             ack_pending;
    logic [7:0]       ack_kind;
    logic [1:0]       ack_res;
    logic             ack_stat;
    logic             send_accepted;
  } item_t;

endpackage

`default_nettype wire

// ----- rtl/dpss_in_reg.sv -----
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted item until the scheduler engine takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dpss_in_reg (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire dpss_pkg::item_t item_i,
  output logic                item_valid_o,
  output dpss_pkg::item_t     item_o,
  input  wire                 item_take_i
);
  import dpss_pkg::*;

  logic  valid_q;
  item_t item_q;

  // The register can load when it is empty or its item leaves in this cycle.
  assign in_ready_o   = !valid_q || item_take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dpss_engine.sv -----
// ----------------------------------------------------------------------------
// Scheduler engine
// Dirty bits, send state and counters, updated once per item, with the
// result register on the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module dpss_engine #(
  parameter int CntW = dpss_pkg::COUNTER_BITS
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire [dpss_pkg::CFG_W-1:0]    entry_count_i,
  input  wire                          item_valid_i,
  input  wire dpss_pkg::item_t         item_i,
  output logic                         item_take_o,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic                         send_valid_o,
  output logic [dpss_pkg::IDX_W-1:0]   send_index_o,
  output logic                         busy_sending_o,
  output logic [dpss_pkg::ENT_W-1:0]   inflight_index_o,
  output logic [dpss_pkg::ENT_W-1:0]   failed_index_o,
  output logic [1:0]                   result_code_o,
  output logic                         status_code_o,
  output logic [dpss_pkg::ENT_W-1:0]   pending_total_o,
  output logic [CntW-1:0]              ok_total_o,
  output logic [CntW-1:0]              fail_total_o,
  output logic [CntW-1:0]              send_total_o,
  output logic [1:0]                   command_status_o
);
  import dpss_pkg::*;

  // Architectural state.
  logic [MAX_ENTRIES-1:0] dirty_q, dirty_d;
  logic                   sending_q, sending_d;
  logic [ENT_W-1:0]       active_q, active_d;
  logic [ENT_W-1:0]       failed_q, failed_d;
  logic [1:0]             last_res_q, last_res_d;
  logic                   last_stat_q, last_stat_d;
  logic [CntW-1:0]        ok_cnt_q, ok_cnt_d;
  logic [CntW-1:0]        fail_cnt_q, fail_cnt_d;
  logic [CntW-1:0]        send_cnt_q, send_cnt_d;

  // Result register.
  logic                   out_valid_q;
  logic                   send_valid_q, send_valid_d;
  logic [IDX_W-1:0]       send_index_q, send_index_d;
  logic [ENT_W-1:0]       pending_q, pending_d;
  logic [1:0]             cmd_q, cmd_d;

  logic [ENT_W-1:0]       used_n;
  logic [MAX_ENTRIES-1:0] in_use;
  logic [MAX_ENTRIES-1:0] cand;
  logic                   cand_found;
  logic [IDX_W-1:0]       cand_idx;
  logic                   can_edit;
  logic                   ack_taken;
  logic                   active_in_use;

  assign item_take_o = item_valid_i && (!out_valid_q || out_ready_i);

  // A count above the table size acts as the table size.
  assign used_n = (entry_count_i > CFG_W'(MAX_ENTRIES)) ? NONE_ENTRY
                                                        : ENT_W'(entry_count_i);

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      in_use[i] = (ENT_W'(i) < used_n);
    end
  end

  assign cand = dirty_q & in_use;

  // Lowest dirty entry in use.
  always_comb begin
    cand_found = 1'b0;
    cand_idx   = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        cand_found = 1'b1;
        cand_idx   = IDX_W'(i);
      end
    end
  end

  assign can_edit      = item_i.link_online &&
                         (!item_i.control_enabled || item_i.emergency_stop);
  assign ack_taken     = !item_i.ack_pending && (item_i.ack_kind == ACK_TYPE_SET_PARAM) &&
                         (item_i.ack_res != RES_NONE);
  assign active_in_use = (active_q < used_n);

  always_comb begin
    dirty_d      = dirty_q;
    sending_d    = sending_q;
    active_d     = active_q;
    failed_d     = failed_q;
    last_res_d   = last_res_q;
    last_stat_d  = last_stat_q;
    ok_cnt_d     = ok_cnt_q;
    fail_cnt_d   = fail_cnt_q;
    send_cnt_d   = send_cnt_q;
    send_valid_d = 1'b0;
    send_index_d = '0;
    cmd_d        = CMD_DONE;

    case (item_i.mode)
      MODE_MARK: begin
        if ({1'b0, item_i.param_index} < used_n) begin
          dirty_d[item_i.param_index] = 1'b1;
        end
      end
      MODE_MARK_ALL: begin
        if (!item_i.link_online) begin
          cmd_d = CMD_OFFLINE;
        end else if (!can_edit) begin
          cmd_d = CMD_VEH_ACTIVE;
        end else begin
          dirty_d = dirty_q | in_use;
        end
      end
      MODE_TICK: begin
        if (sending_q) begin
          if (ack_taken) begin
            // A result code of three counts as a failure.
            last_res_d  = (item_i.ack_res == RES_OK) ? RES_OK : RES_FAIL;
            last_stat_d = item_i.ack_stat;
            if (active_in_use) begin
              dirty_d[active_q[IDX_W-1:0]] = 1'b0;
            end
            if ((item_i.ack_res == RES_OK) && (item_i.ack_stat == STAT_OK) &&
                active_in_use) begin
              ok_cnt_d = ok_cnt_q + CntW'(1);
            end else begin
              failed_d   = active_q;
              fail_cnt_d = fail_cnt_q + CntW'(1);
            end
            sending_d = 1'b0;
            active_d  = NONE_ENTRY;
          end
        end else if (can_edit && !item_i.ack_pending && cand_found) begin
          send_valid_d = 1'b1;
          send_index_d = cand_idx;
          last_stat_d  = STAT_ERR;
          if (item_i.send_accepted) begin
            sending_d  = 1'b1;
            active_d   = {1'b0, cand_idx};
            last_res_d = RES_NONE;
            send_cnt_d = send_cnt_q + CntW'(1);
          end else begin
            // A refused send drops the entry and is logged as a failure.
            dirty_d[cand_idx] = 1'b0;
            failed_d          = {1'b0, cand_idx};
            last_res_d        = RES_FAIL;
            fail_cnt_d        = fail_cnt_q + CntW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Dirty entries in use after this item.
  always_comb begin
    pending_d = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      pending_d = pending_d + ENT_W'(dirty_d[i] && in_use[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_q     <= '0;
      sending_q   <= 1'b0;
      active_q    <= NONE_ENTRY;
      failed_q    <= NONE_ENTRY;
      last_res_q  <= RES_NONE;
      last_stat_q <= STAT_OK;
      ok_cnt_q    <= '0;
      fail_cnt_q  <= '0;
      send_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_take_o) begin
        dirty_q     <= dirty_d;
        sending_q   <= sending_d;
        active_q    <= active_d;
        failed_q    <= failed_d;
        last_res_q  <= last_res_d;
        last_stat_q <= last_stat_d;
        ok_cnt_q    <= ok_cnt_d;
        fail_cnt_q  <= fail_cnt_d;
        send_cnt_q  <= send_cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      send_valid_q <= send_valid_d;
      send_index_q <= send_index_d;
      pending_q    <= pending_d;
      cmd_q        <= cmd_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign send_valid_o     = send_valid_q;
  assign send_index_o     = send_index_q;
  assign busy_sending_o   = sending_q;
  assign inflight_index_o = active_q;
  assign failed_index_o   = failed_q;
  assign result_code_o    = last_res_q;
  assign status_code_o    = last_stat_q;
  assign pending_total_o  = pending_q;
  assign ok_total_o       = ok_cnt_q;
  assign fail_total_o     = fail_cnt_q;
  assign send_total_o     = send_cnt_q;
  assign command_status_o = cmd_q;

endmodule

`default_nettype wire

// ----- rtl/dirty_param_sync_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// Dirty parameter sync scheduler
// Tracks dirty shadowed parameters and issues one send at a time to a peer.
//
//   Channel  Direction  Handshake                  Payload
//   cfg      in         cfg_valid_i / cfg_ready_o  cfg_data_i (entry count)
//   in       in         in_valid_i / in_ready_o    mode_i .. send_accepted_i
//   out      out        out_valid_o / out_ready_i  send_valid_o .. command_status_o
//
// One item is accepted per cycle while the output is not stalled. Each item
// waits in the input register; the engine takes it and registers its result.
// A stalled output holds the result and the input register, which then fills
// and drops in_ready_o. Reset clears all dirty bits, counters and send state.
// The configuration port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module dirty_param_sync_scheduler_core #(
  parameter int CounterBits = dpss_pkg::COUNTER_BITS
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [dpss_pkg::CFG_W-1:0]    cfg_data_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire [1:0]                    mode_i,
  input  wire [dpss_pkg::IDX_W-1:0]    param_index_i,
  input  wire                          link_online_i,
  input  wire                          control_enabled_i,
  input  wire                          emergency_stop_i,
  input  wire                          ack_pending_i,
  input  wire [7:0]                    ack_type_i,
  input  wire [1:0]                    ack_result_i,
  input  wire                          ack_status_i,
  input  wire                          send_accepted_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic                         send_valid_o,
  output logic [dpss_pkg::IDX_W-1:0]   send_index_o,
  output logic                         busy_sending_o,
  output logic [dpss_pkg::ENT_W-1:0]   inflight_index_o,
  output logic [dpss_pkg::ENT_W-1:0]   failed_index_o,
  output logic [1:0]                   result_code_o,
  output logic                         status_code_o,
  output logic [dpss_pkg::ENT_W-1:0]   pending_total_o,
  output logic [CounterBits-1:0]       ok_total_o,
  output logic [CounterBits-1:0]       fail_total_o,
  output logic [CounterBits-1:0]       send_total_o,
  output logic [1:0]                   command_status_o
);
  import dpss_pkg::*;

  logic [CFG_W-1:0] entry_count_q;
  item_t            in_item;
  item_t            reg_item;
  logic             reg_valid;
  logic             reg_take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_valid_i) begin
      entry_count_q <= cfg_data_i;
    end
  end

  always_comb begin
    in_item.mode            = mode_i;
    in_item.param_index     = param_index_i;
    in_item.link_online     = link_online_i;
    in_item.control_enabled = control_enabled_i;
    in_item.emergency_stop  = emergency_stop_i;
    in_item.ack_pending     = ack_pending_i;
    in_item.ack_kind        = ack_type_i;
    in_item.ack_res         = ack_result_i;
    in_item.ack_stat        = ack_status_i;
    in_item.send_accepted   = send_accepted_i;
  end

  dpss_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (in_item),
    .item_valid_o (reg_valid),
    .item_o       (reg_item),
    .item_take_i  (reg_take)
  );

  dpss_engine #(
    .CntW (CounterBits)
  ) u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .entry_count_i    (entry_count_q),
    .item_valid_i     (reg_valid),
    .item_i           (reg_item),
    .item_take_o      (reg_take),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .send_valid_o     (send_valid_o),
    .send_index_o     (send_index_o),
    .busy_sending_o   (busy_sending_o),
    .inflight_index_o (inflight_index_o),
    .failed_index_o   (failed_index_o),
    .result_code_o    (result_code_o),
    .status_code_o    (status_code_o),
    .pending_total_o  (pending_total_o),
    .ok_total_o       (ok_total_o),
    .fail_total_o     (fail_total_o),
    .send_total_o     (send_total_o),
    .command_status_o (command_status_o)
  );

endmodule

`default_nettype wire

// ----- test/dpss_sync_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dirty parameter sync scheduler checker
// Watches the configuration, input and result channels of the scheduler. It
// keeps its own copy of the dirty bits, send state and counters. For every
// accepted item it predicts the result, and it compares each accepted result
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module dpss_sync_checker (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_valid_i,
  input  wire                                cfg_ready_i,
  input  wire [dpss_pkg::CFG_W-1:0]          cfg_data_i,
  input  wire                                in_valid_i,
  input  wire                                in_ready_i,
  input  dpss_pkg::item_t                    item_i,
  input  wire                                out_valid_i,
  input  wire                                out_ready_i,
  input  wire                                send_valid_i,
  input  wire [dpss_pkg::IDX_W-1:0]          send_index_i,
  input  wire                                busy_sending_i,
  input  wire [dpss_pkg::ENT_W-1:0]          inflight_index_i,
  input  wire [dpss_pkg::ENT_W-1:0]          failed_index_i,
  input  wire [1:0]                          result_code_i,
  input  wire                                status_code_i,
  input  wire [dpss_pkg::ENT_W-1:0]          pending_total_i,
  input  wire [dpss_pkg::COUNTER_BITS-1:0]   ok_total_i,
  input  wire [dpss_pkg::COUNTER_BITS-1:0]   fail_total_i,
  input  wire [dpss_pkg::COUNTER_BITS-1:0]   send_total_i,
  input  wire [1:0]                          command_status_i,
  output int                                 results_owed_o,
  output int                                 mismatches_o
);
  import dpss_pkg::*;

  typedef struct packed {
    logic                    send_valid;
    logic [IDX_W-1:0]        send_index;
    logic                    busy;
    logic [ENT_W-1:0]        inflight;
    logic [ENT_W-1:0]        failed;
    logic [1:0]              result;
    logic                    status;
    logic [ENT_W-1:0]        pending;
    logic [COUNTER_BITS-1:0] ok_tot;
    logic [COUNTER_BITS-1:0] fail_tot;
    logic [COUNTER_BITS-1:0] send_tot;
    logic [1:0]              cmd;
  } sync_status_t;

  logic [MAX_ENTRIES-1:0]  dirty;
  logic                    sending;
  logic [ENT_W-1:0]        active;
  logic [ENT_W-1:0]        failed_entry;
  logic [1:0]              last_res;
  logic                    last_stat;
  logic [COUNTER_BITS-1:0] ok_cnt;
  logic [COUNTER_BITS-1:0] fail_cnt;
  logic [COUNTER_BITS-1:0] send_cnt;
  logic [CFG_W-1:0]        entry_limit;

  sync_status_t status_q[$];
  sync_status_t observed;
  sync_status_t wanted;
  int           results_seen = 0;

  assign observed = '{send_valid_i, send_index_i, busy_sending_i, inflight_index_i,
                      failed_index_i, result_code_i, status_code_i, pending_total_i,
                      ok_total_i, fail_total_i, send_total_i, command_status_i};

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
    mismatches_o++;
  endtask

  // Applies one item to the shadow state and returns the status it leaves.
  function automatic sync_status_t predict_sync(input item_t it);
    sync_status_t r;
    int unsigned  used;
    int unsigned  pick;
    logic         can_edit;
    r        = '0;
    used     = (entry_limit > MAX_ENTRIES) ? MAX_ENTRIES : entry_limit;
    can_edit = it.link_online && (!it.control_enabled || it.emergency_stop);
    case (it.mode)
      MODE_MARK: begin
        if (it.param_index < used) dirty[it.param_index] = 1'b1;
      end
      MODE_MARK_ALL: begin
        if (!it.link_online) begin
          r.cmd = CMD_OFFLINE;
        end else if (!can_edit) begin
          r.cmd = CMD_VEH_ACTIVE;
        end else begin
          for (int i = 0; i < used; i++) dirty[i] = 1'b1;
        end
      end
      MODE_TICK: begin
        if (sending) begin
          if (!it.ack_pending && it.ack_kind == ACK_TYPE_SET_PARAM &&
              it.ack_res != RES_NONE) begin
            last_res  = (it.ack_res == RES_OK) ? RES_OK : RES_FAIL;
            last_stat = it.ack_stat;
            // An entry beyond a shrunken count keeps its bit.
            if (active < used) dirty[active[IDX_W-1:0]] = 1'b0;
            if (it.ack_res == RES_OK && it.ack_stat == STAT_OK && active < used) begin
              ok_cnt++;
            end else begin
              failed_entry = active;
              fail_cnt++;
            end
            sending = 1'b0;
            active  = NONE_ENTRY;
          end
        end else if (can_edit && !it.ack_pending) begin
          pick = used;
          for (int i = 0; i < used; i++) begin
            if (dirty[i] && pick == used) pick = i;
          end
          if (pick < used) begin
            r.send_valid = 1'b1;
            r.send_index = IDX_W'(pick);
            if (it.send_accepted) begin
              sending   = 1'b1;
              active    = ENT_W'(pick);
              last_res  = RES_NONE;
              last_stat = STAT_ERR;
              send_cnt++;
            end else begin
              dirty[pick]  = 1'b0;
              failed_entry = ENT_W'(pick);
              last_res     = RES_FAIL;
              last_stat    = STAT_ERR;
              fail_cnt++;
            end
          end
        end
      end
      default: ;
    endcase
    r.busy     = sending;
    r.inflight = active;
    r.failed   = failed_entry;
    r.result   = last_res;
    r.status   = last_stat;
    r.ok_tot   = ok_cnt;
    r.fail_tot = fail_cnt;
    r.send_tot = send_cnt;
    for (int i = 0; i < used; i++) r.pending += ENT_W'(dirty[i]);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty          = '0;
      sending        = 1'b0;
      active         = NONE_ENTRY;
      failed_entry   = NONE_ENTRY;
      last_res       = RES_NONE;
      last_stat      = STAT_OK;
      ok_cnt         = '0;
      fail_cnt       = '0;
      send_cnt       = '0;
      entry_limit    = '0;
      status_q.delete();
      results_owed_o = 0;
      mismatches_o   = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (status_q.size() == 0) begin
          report_mismatch("unexpected result, items owed", 1, 0);
        end else begin
          wanted = status_q.pop_front();
          if (observed.send_valid !== wanted.send_valid)
            report_mismatch("send_valid", observed.send_valid, wanted.send_valid);
          if (observed.send_index !== wanted.send_index)
            report_mismatch("send_index", observed.send_index, wanted.send_index);
          if (observed.busy !== wanted.busy)
            report_mismatch("busy_sending", observed.busy, wanted.busy);
          if (observed.inflight !== wanted.inflight)
            report_mismatch("inflight_index", observed.inflight, wanted.inflight);
          if (observed.failed !== wanted.failed)
            report_mismatch("failed_index", observed.failed, wanted.failed);
          if (observed.result !== wanted.result)
            report_mismatch("result_code", observed.result, wanted.result);
          if (observed.status !== wanted.status)
            report_mismatch("status_code", observed.status, wanted.status);
          if (observed.pending !== wanted.pending)
            report_mismatch("pending_total", observed.pending, wanted.pending);
          if (observed.ok_tot !== wanted.ok_tot)
            report_mismatch("ok_total", observed.ok_tot, wanted.ok_tot);
          if (observed.fail_tot !== wanted.fail_tot)
            report_mismatch("fail_total", observed.fail_tot, wanted.fail_tot);
          if (observed.send_tot !== wanted.send_tot)
            report_mismatch("send_total", observed.send_tot, wanted.send_tot);
          if (observed.cmd !== wanted.cmd)
            report_mismatch("command_status", observed.cmd, wanted.cmd);
        end
        results_seen++;
      end
      if (cfg_valid_i && cfg_ready_i) entry_limit = cfg_data_i;
      if (in_valid_i && in_ready_i) status_q.push_back(predict_sync(item_i));
      results_owed_o = status_q.size();
    end
  end

endmodule

// ----- test/tb_dirty_param_sync_scheduler_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dirty parameter sync scheduler testbench
// Drives a directed sequence through every mode, acknowledge outcome and
// refusal, then random phases under several entry counts, with random idle
// gaps on the input side and random stalls on the result side. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_dirty_param_sync_scheduler_core;
  import dpss_pkg::*;

  // Mode code with no function, and an acknowledge result outside the defined codes.
  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam logic [1:0] RES_RSVD = 2'd3;
  localparam int         PHASE_ITEMS = 180;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_W-1:0]        cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  item_t                   cur_item = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic                    send_valid_o;
  logic [IDX_W-1:0]        send_index_o;
  logic                    busy_sending_o;
  logic [ENT_W-1:0]        inflight_index_o;
  logic [ENT_W-1:0]        failed_index_o;
  logic [1:0]              result_code_o;
  logic                    status_code_o;
  logic [ENT_W-1:0]        pending_total_o;
  logic [COUNTER_BITS-1:0] ok_total_o;
  logic [COUNTER_BITS-1:0] fail_total_o;
  logic [COUNTER_BITS-1:0] send_total_o;
  logic [1:0]              command_status_o;
  int                      results_owed;
  int                      mismatches;
  bit                      quiet = 1'b0;
  int                      stall_left = 0;
  int                      stall_draw;
  logic [CFG_W-1:0]        phase_counts [10] = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd7,
                                                 5'd16, 5'd3, 5'd20, 5'd12, 5'd16};

  dirty_param_sync_scheduler_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .mode_i(cur_item.mode), .param_index_i(cur_item.param_index),
    .link_online_i(cur_item.link_online), .control_enabled_i(cur_item.control_enabled),
    .emergency_stop_i(cur_item.emergency_stop), .ack_pending_i(cur_item.ack_pending),
    .ack_type_i(cur_item.ack_kind), .ack_result_i(cur_item.ack_res),
    .ack_status_i(cur_item.ack_stat), .send_accepted_i(cur_item.send_accepted),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .send_valid_o(send_valid_o), .send_index_o(send_index_o),
    .busy_sending_o(busy_sending_o), .inflight_index_o(inflight_index_o),
    .failed_index_o(failed_index_o), .result_code_o(result_code_o),
    .status_code_o(status_code_o), .pending_total_o(pending_total_o),
    .ok_total_o(ok_total_o), .fail_total_o(fail_total_o), .send_total_o(send_total_o),
    .command_status_o(command_status_o)
  );

  dpss_sync_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_i(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_i(in_ready_o), .item_i(cur_item),
    .out_valid_i(out_valid_o), .out_ready_i(out_ready_i),
    .send_valid_i(send_valid_o), .send_index_i(send_index_o),
    .busy_sending_i(busy_sending_o), .inflight_index_i(inflight_index_o),
    .failed_index_i(failed_index_o), .result_code_i(result_code_o),
    .status_code_i(status_code_o), .pending_total_i(pending_total_o),
    .ok_total_i(ok_total_o), .fail_total_i(fail_total_o), .send_total_i(send_total_o),
    .command_status_i(command_status_o),
    .results_owed_o(results_owed), .mismatches_o(mismatches)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Result side: after each taken result, hold ready low for a randomly drawn stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else if (out_valid_o && out_ready_i) begin
      stall_draw = quiet ? 0 : $urandom_range(0, 17);
      stall_left  <= stall_draw;
      out_ready_i <= (stall_draw == 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left  <= 0;
      out_ready_i <= 1'b1;
    end
  end

  function automatic item_t make_item(input logic [1:0] mode, input logic [IDX_W-1:0] idx,
                                      input int online, input int ctrl,
                                      input int estop, input int pend,
                                      input logic [7:0] atype, input logic [1:0] ares,
                                      input logic astat, input int acc);
    item_t it;
    it = '{mode, idx, online[0], ctrl[0], estop[0], pend[0], atype, ares, astat, acc[0]};
    return it;
  endfunction

  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    logic [31:0] raw;
    raw = $urandom;
    it  = raw[$bits(item_t)-1:0];
    // Most items form plausible traffic so that sends and acknowledges progress.
    if ($urandom_range(0, 9) < 8) begin
      pick = $urandom_range(0, 99);
      if (pick < 58)      it.mode = MODE_TICK;
      else if (pick < 88) it.mode = MODE_MARK;
      else if (pick < 97) it.mode = MODE_MARK_ALL;
      else                it.mode = MODE_NOP;
      it.link_online     = ($urandom_range(0, 15) != 0);
      it.control_enabled = ($urandom_range(0, 3) == 0);
      it.ack_pending     = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 7) != 0) it.ack_kind = ACK_TYPE_SET_PARAM;
      pick = $urandom_range(0, 9);
      if (pick == 0)      it.ack_res = RES_NONE;
      else if (pick == 1) it.ack_res = RES_RSVD;
      else if (pick < 4)  it.ack_res = RES_FAIL;
      else                it.ack_res = RES_OK;
      it.ack_stat      = ($urandom_range(0, 4) == 0) ? STAT_ERR : STAT_OK;
      it.send_accepted = ($urandom_range(0, 4) != 0);
    end
    return it;
  endfunction

  // Offers one item after a drawn idle gap and returns at the edge that takes it.
  task automatic push_item(input item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cur_item   <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (results_owed != 0);
    @(posedge clk_i);
  endtask

  task automatic write_count(input logic [CFG_W-1:0] count);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= count;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    #1_000_000;
    $display("tb_dirty_param_sync_scheduler_core NOT OK");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // No entries in use: marks do nothing and a tick finds nothing to send.
    push_item(make_item(MODE_MARK, 4'd0, 1, 0, 0, 0, ACK_TYPE_SET_PARAM, RES_OK, STAT_OK, 1));
    push_item(make_item(MODE_MARK_ALL, 4'd0, 1, 0, 0, 0, 8'hFF, RES_OK, STAT_OK, 1));
    push_item(make_item(MODE_TICK, 4'd0, 1, 0, 0, 0, ACK_TYPE_SET_PARAM, RES_OK, STAT_OK, 1));
    push_item(make_item(MODE_NOP, 4'd15, 1, 1, 1, 1, 8'hFF, RES_RSVD, STAT_ERR, 1));

    write_count(5'd16);
    push_item(make_item(MODE_MARK, 4'd15, 1, 0, 0, 0, 8'h00, RES_NONE, STAT_OK, 0));
    push_item(make_item(MODE_MARK, 4'd0, 0, 1, 0, 1, 8'hFF, RES_RSVD, STAT_ERR, 0));
    push_item(make_item(MODE_MARK_ALL, 4'd0, 0, 0, 0, 0, ACK_TYPE_SET_PARAM, RES_OK, STAT_OK, 1));
    push_item(make_item(MODE_MARK_ALL, 4'd0, 1, 1, 0, 0, ACK_TYPE_SET_PARAM, RES_OK, STAT_OK, 1));
    push_item(make_item(MODE_MARK_ALL, 4'd0, 1, 1, 1, 0, ACK_TYPE_SET_PARAM, RES_OK, STAT_OK, 1));
    // Blocked ticks: offline, vehicle active, link still waiting.
    push_item(make_item(MODE_TICK, 4'd0, 0, 0, 0, 0, ACK_TYPE_SET_PARAM, RES_OK, STAT_OK, 1));
    push_item(make_item(MODE_TICK, 4'd0, 1, 1, 0, 0, ACK_TYPE_SET_PARAM, RES_OK, STAT_OK, 1));
    push_item(make_item(MODE_TICK, 4'd0, 1, 0, 0, 1, ACK_TYPE_SET_PARAM, RES_OK, STAT_OK, 1));
    push_item(make_item(MODE_TICK, 4'd0, 1, 0, 0, 0, ACK_TYPE_SET_PARAM, RES_OK, STAT_OK, 1));
    // While sending, acknowledges that do not match leave the tick waiting.
    push_item(make_item(MODE_TICK, 4'd0, 1, 0, 0, 1, ACK_TYPE_SET_PARAM, RES_OK, STAT_OK, 1));
    push_item(make_item(MODE_TICK, 4'd0, 1, 0, 0, 0, 8'hFF, RES_OK, STAT_OK, 1));
    push_item(make_item(MODE_TICK, 4'd0, 1, 0, 0, 0, ACK_TYPE_SET_PARAM, RES_NONE, STAT_OK, 1));
    push_item(make_item(MODE_TICK, 4'd0, 0, 1, 0, 0, ACK_TYPE_SET_PARAM, RES_OK, STAT_OK, 0));
    push_item(make_item(MODE_TICK, 4'd0, 1, 0, 0, 0, ACK_TYPE_SET_PARAM, RES_OK, STAT_OK, 0));
    push_item(make_item(MODE_TICK, 4'd0, 1, 0, 0, 0, ACK_TYPE_SET_PARAM, RES_OK, STAT_OK, 1));
    push_item(make_item(MODE_TICK, 4'd0, 1, 0, 0, 0, ACK_TYPE_SET_PARAM, RES_RSVD, STAT_OK, 1));
    push_item(make_item(MODE_TICK, 4'd0, 1, 0, 0, 0, ACK_TYPE_SET_PARAM, RES_OK, STAT_OK, 1));
    push_item(make_item(MODE_TICK, 4'd0, 1, 0, 0, 0, ACK_TYPE_SET_PARAM, RES_OK, STAT_ERR, 1));
    push_item(make_item(MODE_TICK, 4'd0, 1, 0, 0, 0, ACK_TYPE_SET_PARAM, RES_FAIL, STAT_OK, 1));
    // Shrink the count below the entry in flight, then acknowledge it.
    write_count(5'd2);
    push_item(make_item(MODE_TICK, 4'd0, 1, 0, 0, 0, ACK_TYPE_SET_PARAM, RES_OK, STAT_OK, 1));

    foreach (phase_counts[p]) begin
      write_count(phase_counts[p]);
      quiet = (p % 3 == 2);
      repeat (PHASE_ITEMS) push_item(random_item());
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) $display("tb_dirty_param_sync_scheduler_core OK");
    else $display("tb_dirty_param_sync_scheduler_core NOT OK");
    $finish;
  end

endmodule
